// ===== sv/otp_pkg.sv =====
package otp_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int COUNT_WIDTH = 32;

  localparam int TIMER_IDX_W = $clog2(NUM_TIMERS);
  localparam int FREE_CNT_W  = $clog2(NUM_TIMERS + 1);

  // stream field widths
  localparam int MODE_W   = 3;
  localparam int ID_W     = 4;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;

  // input tdata layout
  localparam int IN_MODE_LSB   = 0;
  localparam int IN_ID_LSB     = IN_MODE_LSB + MODE_W;
  localparam int IN_TIME_LSB   = IN_ID_LSB + ID_W;
  localparam int IN_NOTIFY_LSB = IN_TIME_LSB + TIME_W;
  localparam int IN_TDATA_W    = ((IN_NOTIFY_LSB + 1 + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_ID_LSB     = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_REM_LSB    = OUT_ID_LSB + ID_W;
  localparam int OUT_USED_W     = OUT_REM_LSB + TIME_W;
  localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE  = 3'd0,
    MODE_REMOVE  = 3'd1,
    MODE_START   = 3'd2,
    MODE_STOP    = 3'd3,
    MODE_RESTART = 3'd4,
    MODE_READ    = 3'd5,
    MODE_TICK    = 3'd6
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FREE   = 2'd1,
    STATUS_NOT_ALLOC = 2'd2
  } status_e;

  typedef enum logic {
    KIND_RESP   = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_e;

endpackage

// ===== sv/otp_cnt_ram.sv =====
module otp_cnt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/one_shot_timer_pool.sv =====
// Pool of one-shot countdown timers with a LIFO free-id stack.
//
// Input channel s_axis: one command per transfer (create, remove, start,
// stop, restart, read, tick). Output channel m_axis: one response per
// command, tuser = 0; a tick gives one expiry event per expiring timer with a
// handler, tuser = 1, in ascending id order, and no response at all if none
// expires. tlast marks the final result of a command. Mode 7 is dropped.
//
// Timer counts live in a single-port-read, single-port-write RAM with a
// registered read port; flags and the free stack are flops.
// A command first reads the RAM, then does the read-modify-write and loads
// the result register. A tick walks the RAM, one timer per cycle while no
// expiry event waits on a stalled m_axis; the next read is issued while the
// current entry is written back. Commands are taken one at a time.
//
// Reset empties the pool: all ids free, stack top is NUM_TIMERS-1, no result
// pending. When m_axis stalls, the result register holds and the walk or
// command waits on the next result; a new command may still be taken while
// a finished result waits.
module one_shot_timer_pool
  import otp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // mode[2:0], timer_id[6:3], time_value[38:7], notify_enable[39]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // status[1:0], result_id[5:2], remaining[37:6], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // kind[0]
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_TICK_END
  } state_e;

  state_e state_q, state_d;

  mode_e                  cmd_mode_q, cmd_mode_d;
  logic [TIMER_IDX_W-1:0] cmd_idx_q, cmd_idx_d;
  logic                   cmd_ok_q, cmd_ok_d;
  logic [COUNT_WIDTH-1:0] cmd_tv_q, cmd_tv_d;
  logic                   cmd_notify_q, cmd_notify_d;

  logic [TIMER_IDX_W-1:0] walk_q, walk_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [TIMER_IDX_W-1:0] pend_id_q, pend_id_d;

  logic [FREE_CNT_W-1:0]  free_count_q, free_count_d;
  logic [TIMER_IDX_W-1:0] free_stack_q [NUM_TIMERS];
  logic [TIMER_IDX_W-1:0] free_stack_d [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  alloc_q, alloc_d;
  logic [NUM_TIMERS-1:0]  run_q, run_d;
  logic [NUM_TIMERS-1:0]  hdl_q, hdl_d;

  logic                   m_valid_q, m_valid_d;
  kind_e                  m_kind_q, m_kind_d;
  status_e                m_status_q, m_status_d;
  logic [ID_W-1:0]        m_id_q, m_id_d;
  logic [TIME_W-1:0]      m_rem_q, m_rem_d;
  logic                   m_last_q, m_last_d;

  logic                   ram_we;
  logic [TIMER_IDX_W-1:0] ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [TIMER_IDX_W-1:0] ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  logic [MODE_W-1:0]      in_mode;
  logic [ID_W-1:0]        in_id;
  logic [TIME_W-1:0]      in_time;
  logic                   in_notify;
  logic                   in_xfer;
  logic                   out_free;
  logic [FREE_CNT_W-1:0]  fc_m1;
  logic [TIMER_IDX_W-1:0] top_id;
  logic                   act;
  logic [COUNT_WIDTH-1:0] dec;
  logic                   expire;
  logic                   emit;

  assign in_mode   = s_axis_tdata_i[IN_MODE_LSB +: MODE_W];
  assign in_id     = s_axis_tdata_i[IN_ID_LSB +: ID_W];
  assign in_time   = s_axis_tdata_i[IN_TIME_LSB +: TIME_W];
  assign in_notify = s_axis_tdata_i[IN_NOTIFY_LSB];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign fc_m1  = free_count_q - FREE_CNT_W'(1);
  assign top_id = free_stack_q[fc_m1[TIMER_IDX_W-1:0]];

  // tick datapath on the entry being walked
  assign act    = alloc_q[walk_q] && run_q[walk_q];
  assign dec    = (ram_rdata != '0) ? ram_rdata - COUNT_WIDTH'(1) : ram_rdata;
  assign expire = act && (dec == '0);
  assign emit   = expire && hdl_q[walk_q];

  otp_cnt_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (COUNT_WIDTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cmd_mode_d   = cmd_mode_q;
    cmd_idx_d    = cmd_idx_q;
    cmd_ok_d     = cmd_ok_q;
    cmd_tv_d     = cmd_tv_q;
    cmd_notify_d = cmd_notify_q;
    walk_d       = walk_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    free_count_d = free_count_q;
    free_stack_d = free_stack_q;
    alloc_d      = alloc_q;
    run_d        = run_q;
    hdl_d        = hdl_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    m_kind_d     = m_kind_q;
    m_status_d   = m_status_q;
    m_id_d       = m_id_q;
    m_rem_d      = m_rem_q;
    m_last_d     = m_last_q;
    ram_we       = 1'b0;
    ram_waddr    = cmd_idx_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = in_id[TIMER_IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_mode_d   = mode_e'(in_mode);
          cmd_idx_d    = in_id[TIMER_IDX_W-1:0];
          cmd_ok_d     = (32'(in_id) < NUM_TIMERS);
          cmd_tv_d     = in_time[COUNT_WIDTH-1:0];
          cmd_notify_d = in_notify;
          case (mode_e'(in_mode))
            MODE_TICK: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              walk_d    = '0;
              state_d   = ST_TICK;
            end
            MODE_CREATE, MODE_REMOVE, MODE_START, MODE_STOP, MODE_RESTART,
            MODE_READ: begin
              ram_re  = 1'b1;
              state_d = ST_EXEC;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_kind_d   = KIND_RESP;
          m_status_d = STATUS_OK;
          m_id_d     = '0;
          m_rem_d    = '0;
          m_last_d   = 1'b1;
          state_d    = ST_IDLE;
          if (cmd_mode_q == MODE_CREATE) begin
            if (free_count_q == '0) begin
              m_status_d = STATUS_NO_FREE;
            end else begin
              free_count_d    = fc_m1;
              alloc_d[top_id] = 1'b1;
              run_d[top_id]   = 1'b0;
              hdl_d[top_id]   = cmd_notify_q;
              ram_we          = 1'b1;
              ram_waddr       = top_id;
              ram_wdata       = '0;
              m_id_d          = ID_W'(top_id);
            end
          end else if (!(cmd_ok_q && alloc_q[cmd_idx_q])) begin
            m_status_d = STATUS_NOT_ALLOC;
          end else begin
            case (cmd_mode_q)
              MODE_REMOVE: begin
                alloc_d[cmd_idx_q] = 1'b0;
                run_d[cmd_idx_q]   = 1'b0;
                hdl_d[cmd_idx_q]   = 1'b0;
                ram_we             = 1'b1;
                ram_wdata          = '0;
                if (32'(free_count_q) < NUM_TIMERS) begin
                  free_stack_d[free_count_q[TIMER_IDX_W-1:0]] = cmd_idx_q;
                  free_count_d = free_count_q + FREE_CNT_W'(1);
                end
              end
              MODE_START: begin
                ram_we           = 1'b1;
                ram_wdata        = cmd_tv_q;
                run_d[cmd_idx_q] = 1'b1;
              end
              MODE_STOP: begin
                run_d[cmd_idx_q] = 1'b0;
              end
              MODE_RESTART: begin
                if (ram_rdata >= cmd_tv_q) begin
                  ram_we    = 1'b1;
                  ram_wdata = cmd_tv_q;
                end
              end
              MODE_READ: begin
                m_rem_d = TIME_W'(ram_rdata);
              end
              default: begin
                m_status_d = STATUS_OK;
              end
            endcase
          end
        end
      end

      ST_TICK: begin
        // an event is held back until the next one is found so the final one can carry tlast
        if (!(emit && pend_valid_q && !out_free)) begin
          if (act) begin
            ram_we    = 1'b1;
            ram_waddr = walk_q;
            ram_wdata = dec;
          end
          if (expire) begin
            run_d[walk_q] = 1'b0;
          end
          if (emit) begin
            if (pend_valid_q) begin
              m_valid_d  = 1'b1;
              m_kind_d   = KIND_EXPIRY;
              m_status_d = STATUS_OK;
              m_id_d     = ID_W'(pend_id_q);
              m_rem_d    = '0;
              m_last_d   = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = walk_q;
          end
          if (walk_q == TIMER_IDX_W'(NUM_TIMERS - 1)) begin
            state_d = ST_TICK_END;
          end else begin
            walk_d    = walk_q + TIMER_IDX_W'(1);
            ram_re    = 1'b1;
            ram_raddr = walk_q + TIMER_IDX_W'(1);
          end
        end
      end

      ST_TICK_END: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          m_valid_d    = 1'b1;
          m_kind_d     = KIND_EXPIRY;
          m_status_d   = STATUS_OK;
          m_id_d       = ID_W'(pend_id_q);
          m_rem_d      = '0;
          m_last_d     = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_mode_q   <= MODE_CREATE;
      cmd_idx_q    <= '0;
      cmd_ok_q     <= 1'b0;
      cmd_tv_q     <= '0;
      cmd_notify_q <= 1'b0;
      walk_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_id_q    <= '0;
      free_count_q <= FREE_CNT_W'(NUM_TIMERS);
      for (int i = 0; i < NUM_TIMERS; i++) begin
        free_stack_q[i] <= TIMER_IDX_W'(i);
      end
      alloc_q      <= '0;
      run_q        <= '0;
      hdl_q        <= '0;
      m_valid_q    <= 1'b0;
      m_kind_q     <= KIND_RESP;
      m_status_q   <= STATUS_OK;
      m_id_q       <= '0;
      m_rem_q      <= '0;
      m_last_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmd_mode_q   <= cmd_mode_d;
      cmd_idx_q    <= cmd_idx_d;
      cmd_ok_q     <= cmd_ok_d;
      cmd_tv_q     <= cmd_tv_d;
      cmd_notify_q <= cmd_notify_d;
      walk_q       <= walk_d;
      pend_valid_q <= pend_valid_d;
      pend_id_q    <= pend_id_d;
      free_count_q <= free_count_d;
      free_stack_q <= free_stack_d;
      alloc_q      <= alloc_d;
      run_q        <= run_d;
      hdl_q        <= hdl_d;
      m_valid_q    <= m_valid_d;
      m_kind_q     <= m_kind_d;
      m_status_q   <= m_status_d;
      m_id_q       <= m_id_d;
      m_rem_q      <= m_rem_d;
      m_last_q     <= m_last_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({m_rem_q, m_id_q, m_status_q});

  // every id is either on the free stack or allocated
  a_pool_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(free_count_q) + $countones(alloc_q)) == NUM_TIMERS)
    else $error("free count and allocated flags disagree");

  // a held-back expiry must have been flushed before the next command
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_valid_q)
    else $error("expiry event left pending at end of tick");

  a_expiry_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_kind_q == KIND_EXPIRY) |-> (m_status_q == STATUS_OK) && (m_rem_q == '0))
    else $error("expiry event with nonzero status or remaining");

  // a stopped timer can only have been stopped, never started, by a tick
  a_tick_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TICK |=> (run_q & ~$past(run_q)) == '0)
    else $error("tick set a run flag");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import otp_pkg::*;

  localparam int ITEM_GOAL    = 160;
  localparam int MAX_EVENTS   = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int CALM_PERIOD  = 40;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tv;
    logic              notify;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    status_e           status;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] rem;
    logic              last;
  } result_t;

  typedef struct packed {
    cmd_t    cmd;
    int      reps;
    logic    typed;
    result_t want;
  } plan_row_t;

  localparam result_t NO_WANT     = '{KIND_RESP, STATUS_OK, 4'd0, 32'd0, 1'b0};
  localparam result_t RESP_OK     = '{KIND_RESP, STATUS_OK, 4'd0, 32'd0, 1'b1};
  localparam result_t RESP_BAD_ID = '{KIND_RESP, STATUS_NOT_ALLOC, 4'd0, 32'd0, 1'b1};
  localparam result_t RESP_EMPTY  = '{KIND_RESP, STATUS_NO_FREE, 4'd0, 32'd0, 1'b1};

  // directed commands from the reset state; typed rows give answers that follow straight from it
  localparam plan_row_t DIR_PLAN [23] = '{
    '{'{MODE_READ,    4'd0,  32'd0,          1'b0}, 1,  1'b1, RESP_BAD_ID},
    '{'{MODE_TICK,    4'd0,  32'd0,          1'b0}, 1,  1'b0, NO_WANT},
    '{'{MODE_UNUSED,  4'hF,  32'hFFFF_FFFF,  1'b1}, 1,  1'b0, NO_WANT},
    '{'{MODE_CREATE,  4'd0,  32'd0,          1'b1}, 1,  1'b1,
      '{KIND_RESP, STATUS_OK, 4'd15, 32'd0, 1'b1}},
    '{'{MODE_CREATE,  4'hF,  32'hFFFF_FFFF,  1'b0}, 1,  1'b1,
      '{KIND_RESP, STATUS_OK, 4'd14, 32'd0, 1'b1}},
    '{'{MODE_START,   4'hF,  32'hFFFF_FFFF,  1'b0}, 1,  1'b1, RESP_OK},
    '{'{MODE_READ,    4'hF,  32'd0,          1'b0}, 1,  1'b1,
      '{KIND_RESP, STATUS_OK, 4'd0, 32'hFFFF_FFFF, 1'b1}},
    '{'{MODE_RESTART, 4'hF,  32'd0,          1'b0}, 1,  1'b0, NO_WANT},
    '{'{MODE_RESTART, 4'hF,  32'd5,          1'b1}, 1,  1'b0, NO_WANT},
    '{'{MODE_START,   4'hE,  32'd0,          1'b0}, 1,  1'b0, NO_WANT},
    '{'{MODE_TICK,    4'd0,  32'd0,          1'b0}, 1,  1'b0, NO_WANT},
    '{'{MODE_START,   4'hF,  32'd3,          1'b0}, 1,  1'b0, NO_WANT},
    '{'{MODE_START,   4'hF,  32'd2,          1'b0}, 1,  1'b0, NO_WANT},
    '{'{MODE_STOP,    4'hF,  32'd0,          1'b0}, 1,  1'b0, NO_WANT},
    '{'{MODE_READ,    4'hF,  32'd0,          1'b0}, 1,  1'b0, NO_WANT},
    '{'{MODE_REMOVE,  4'hE,  32'd0,          1'b0}, 1,  1'b1, RESP_OK},
    '{'{MODE_REMOVE,  4'hE,  32'd0,          1'b0}, 1,  1'b1, RESP_BAD_ID},
    '{'{MODE_STOP,    4'hE,  32'd0,          1'b0}, 1,  1'b1, RESP_BAD_ID},
    '{'{MODE_CREATE,  4'd0,  32'd0,          1'b1}, 15, 1'b0, NO_WANT},
    '{'{MODE_CREATE,  4'd0,  32'd0,          1'b1}, 1,  1'b1, RESP_EMPTY},
    '{'{MODE_START,   4'hF,  32'd1,          1'b0}, 1,  1'b0, NO_WANT},
    '{'{MODE_START,   4'd0,  32'd1,          1'b0}, 1,  1'b0, NO_WANT},
    '{'{MODE_TICK,    4'd0,  32'd0,          1'b0}, 1,  1'b0, NO_WANT}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tready = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  // shadow copy of the timer pool
  logic [COUNT_WIDTH-1:0] cnt_m     [NUM_TIMERS];
  bit                     run_m     [NUM_TIMERS];
  bit                     alloc_m   [NUM_TIMERS];
  bit                     handler_m [NUM_TIMERS];
  logic [ID_W-1:0]        stack_m   [NUM_TIMERS];
  int                     free_m;

  result_t timer_results_q [$];

  int err_count   = 0;
  int n_sent      = 0;
  int n_ticks     = 0;
  int n_results   = 0;
  int n_expiry    = 0;
  int idle_cycles = 0;
  bit src_calm    = 1'b0;
  bit snk_calm    = 1'b0;

  always #4 clk_i = ~clk_i;

  one_shot_timer_pool dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  function automatic void reset_pool();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      cnt_m[i]     = '0;
      run_m[i]     = 1'b0;
      alloc_m[i]   = 1'b0;
      handler_m[i] = 1'b0;
      stack_m[i]   = ID_W'(i);
    end
    free_m = NUM_TIMERS;
  endfunction

  // Updates the shadow pool for one command and returns what it should emit.
  function automatic void apply_timer_cmd(input cmd_t c, output result_t outs [$]);
    result_t                r;
    logic [COUNT_WIDTH-1:0] tv_n;
    logic [ID_W-1:0]        a;
    bit                     id_ok;
    outs.delete();
    r     = RESP_OK;
    tv_n  = c.tv[COUNT_WIDTH-1:0];
    id_ok = (int'(c.id) < NUM_TIMERS) && alloc_m[c.id];
    if (c.mode == MODE_UNUSED) return;
    if (c.mode == MODE_TICK) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (!alloc_m[i] || !run_m[i]) continue;
        if (cnt_m[i] != '0) cnt_m[i] = cnt_m[i] - 1'b1;
        if (cnt_m[i] == '0) begin
          run_m[i] = 1'b0;
          if (handler_m[i] && outs.size() < MAX_EVENTS) begin
            r.kind = KIND_EXPIRY;
            r.id   = ID_W'(i);
            r.last = 1'b0;
            outs.push_back(r);
          end
        end
      end
      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      return;
    end
    if (c.mode == MODE_CREATE) begin
      if (free_m == 0) begin
        r.status = STATUS_NO_FREE;
      end else begin
        free_m--;
        a            = stack_m[free_m];
        alloc_m[a]   = 1'b1;
        run_m[a]     = 1'b0;
        handler_m[a] = c.notify;
        cnt_m[a]     = '0;
        r.id         = a;
      end
    end else if (!id_ok) begin
      r.status = STATUS_NOT_ALLOC;
    end else begin
      case (c.mode)
        MODE_REMOVE: begin
          alloc_m[c.id]   = 1'b0;
          run_m[c.id]     = 1'b0;
          handler_m[c.id] = 1'b0;
          cnt_m[c.id]     = '0;
          if (free_m < NUM_TIMERS) begin
            stack_m[free_m] = c.id;
            free_m++;
          end
        end
        MODE_START: begin
          cnt_m[c.id] = tv_n;
          run_m[c.id] = 1'b1;
        end
        MODE_STOP:    run_m[c.id] = 1'b0;
        MODE_RESTART: if (cnt_m[c.id] >= tv_n) cnt_m[c.id] = tv_n;
        default:      r.rem = TIME_W'(cnt_m[c.id]);
      endcase
    end
    outs.push_back(r);
  endfunction

  function automatic cmd_t pick_random_cmd();
    cmd_t c;
    int   r;
    int   live [$];
    r        = $urandom_range(0, 99);
    c.notify = 1'($urandom_range(0, 1));
    if (r < 3)        c.mode = MODE_UNUSED;
    else if (r < 16)  c.mode = (free_m == 0 && $urandom_range(0, 3) != 0) ? MODE_REMOVE
                                                                          : MODE_CREATE;
    else if (r < 24)  c.mode = MODE_REMOVE;
    else if (r < 44)  c.mode = MODE_START;
    else if (r < 50)  c.mode = MODE_STOP;
    else if (r < 60)  c.mode = MODE_RESTART;
    else if (r < 70)  c.mode = MODE_READ;
    else              c.mode = MODE_TICK;
    for (int i = 0; i < NUM_TIMERS; i++)
      if (alloc_m[i]) live.push_back(i);
    if (live.size() > 0 && $urandom_range(0, 4) != 0)
      c.id = ID_W'(live[$urandom_range(0, live.size() - 1)]);
    else
      c.id = ID_W'($urandom_range(0, 15));
    // mostly short counts so that ticks actually expire timers
    r = $urandom_range(0, 99);
    if (r < 60)      c.tv = TIME_W'($urandom_range(0, 6));
    else if (r < 75) c.tv = TIME_W'($urandom_range(0, 40));
    else if (r < 90) c.tv = $urandom;
    else begin
      case ($urandom_range(0, 3))
        0:       c.tv = '0;
        1:       c.tv = '1;
        2:       c.tv = 32'h8000_0000;
        default: c.tv = 32'd1;
      endcase
    end
    return c;
  endfunction

  task automatic push_cmd(input cmd_t c, input logic typed, input result_t want);
    result_t               outs [$];
    logic [IN_TDATA_W-1:0] word;
    int unsigned           gap;
    word = '0;
    word[IN_MODE_LSB +: MODE_W]  = c.mode;
    word[IN_ID_LSB +: ID_W]      = c.id;
    word[IN_TIME_LSB +: TIME_W]  = c.tv;
    word[IN_NOTIFY_LSB]          = c.notify;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    apply_timer_cmd(c, outs);
    if (typed) timer_results_q.push_back(want);
    else foreach (outs[k]) timer_results_q.push_back(outs[k]);
    n_sent++;
    if (c.mode == MODE_TICK) n_ticks++;
    if (n_sent % CALM_PERIOD == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin : result_sink
    int unsigned w;
    result_t     exp_r;
    wait (rst_ni === 1'b1);
    forever begin
      w = snk_calm ? 0 : $urandom_range(0, 15);
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid_o !== 1'b1);
      n_results++;
      if (m_axis_tuser_o === KIND_EXPIRY) n_expiry++;
      if (n_results % CALM_PERIOD == 0) snk_calm = !snk_calm;
      if (timer_results_q.size() == 0) begin
        $error("unexpected transfer: kind %0d status %0d id %0d", m_axis_tuser_o,
               m_axis_tdata_o[OUT_STATUS_LSB +: STATUS_W], m_axis_tdata_o[OUT_ID_LSB +: ID_W]);
        err_count++;
      end else begin
        exp_r = timer_results_q.pop_front();
        if (m_axis_tuser_o !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, m_axis_tuser_o);
          err_count++;
        end
        if (m_axis_tdata_o[OUT_STATUS_LSB +: STATUS_W] !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status,
                 m_axis_tdata_o[OUT_STATUS_LSB +: STATUS_W]);
          err_count++;
        end
        if (m_axis_tdata_o[OUT_ID_LSB +: ID_W] !== exp_r.id) begin
          $error("result_id: expected %0d, got %0d", exp_r.id, m_axis_tdata_o[OUT_ID_LSB +: ID_W]);
          err_count++;
        end
        if (m_axis_tdata_o[OUT_REM_LSB +: TIME_W] !== exp_r.rem) begin
          $error("remaining: expected %0h, got %0h", exp_r.rem,
                 m_axis_tdata_o[OUT_REM_LSB +: TIME_W]);
          err_count++;
        end
        if (m_axis_tlast_o !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, m_axis_tlast_o);
          err_count++;
        end
      end
    end
  end

  // run is stuck if neither side moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    cmd_t c;
    int   n_rand;
    reset_pool();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIR_PLAN[k])
      for (int j = 0; j < DIR_PLAN[k].reps; j++)
        push_cmd(DIR_PLAN[k].cmd, DIR_PLAN[k].typed, DIR_PLAN[k].want);
    n_rand = 0;
    while (n_rand < ITEM_GOAL) begin
      c = pick_random_cmd();
      if (c.mode != MODE_UNUSED) n_rand++;
      push_cmd(c, 1'b0, NO_WANT);
    end
    s_tvalid <= 1'b0;
    while (timer_results_q.size() != 0) @(posedge clk_i);
    // a tick with no expiry may still be walking the pool
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d commands (%0d ticks); checked %0d results, %0d of them expiries.",
             n_sent, n_ticks, n_results, n_expiry);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/otp_pkg.sv
sv/otp_cnt_ram.sv
sv/one_shot_timer_pool.sv
test/tb_top.sv
